// File: rtl/ctpts_pkg.sv
// Package for the counter/priority task scheduler.
// Holds the task table row type, command and state codes, and signal masks.
// No dependencies.
package ctpts_pkg;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_SCHED = 3'd1,
		CMD_LOAD  = 3'd2,
		CMD_POST  = 3'd3,
		CMD_STATE = 3'd4
	} cmd_t;

	localparam logic [2:0]  ST_RUNNING       = 3'd0;
	localparam logic [2:0]  ST_INTERRUPTIBLE = 3'd1;
	localparam logic [31:0] SIG_ALRM_BIT     = 32'h0000_2000;
	localparam logic [31:0] SIG_UNBLOCKABLE  = 32'h0004_0100;
	localparam logic [8:0]  CREDIT_INIT      = 9'd15;
	localparam logic [7:0]  PRIO_INIT        = 8'd15;

	typedef struct packed {
		logic        used;
		logic [2:0]  st;
		logic [8:0]  credit;
		logic [7:0]  prio;
		logic [31:0] alarm;
		logic [31:0] pend;
		logic [31:0] blk;
	} row_t;

	localparam int ROW_W = $bits(row_t);

endpackage

// File: rtl/ctpts_if.sv
// Handshake channels of the task scheduler: command input and result output.
// Depends on nothing.
interface ctpts_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic        user_mode;
	logic [31:0] now_ticks;
	logic [5:0]  slot;
	logic        present;
	logic [2:0]  task_state;
	logic [7:0]  priority_req;
	logic [8:0]  credit;
	logic [31:0] alarm_at;
	logic [31:0] blocked_mask;
	logic [31:0] signal_bits;
	modport source (output valid, cmd, user_mode, now_ticks, slot, present, task_state,
		priority_req, credit, alarm_at, blocked_mask, signal_bits, input ready);
	modport sink (input valid, cmd, user_mode, now_ticks, slot, present, task_state,
		priority_req, credit, alarm_at, blocked_mask, signal_bits, output ready);
endinterface

interface ctpts_out_if;
	logic       valid;
	logic       ready;
	logic       switched;
	logic [5:0] next_task;
	logic       none_runnable;
	logic       zero_credit_stall;
	modport source (output valid, switched, next_task, none_runnable, zero_credit_stall,
		input ready);
	modport sink (input valid, switched, next_task, none_runnable, zero_credit_stall,
		output ready);
endinterface

// File: rtl/ctpts_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ctpts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/counter_priority_task_scheduler.sv
// Load writes its row when accepted; tick, post and state read a row and write
// it back; a scheduling pass, which a tick can also start, scans every row, and
// scans the table again when credits are refreshed. One item in work at a time,
// set by the one read port of the task table RAM.
// After reset a clearing pass writes every table row before the first command
// is taken. A finished result waits in an output register while the next
// command is accepted.
// Uses ctpts_pkg, ctpts_if and ctpts_ram.
module counter_priority_task_scheduler
	import ctpts_pkg::*;
#(
	parameter int TASK_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	ctpts_in_if.sink    in_ch,
	ctpts_out_if.source out_ch
);

	localparam int IW = $clog2(TASK_SLOTS);
	localparam logic [IW-1:0] LAST = IW'(TASK_SLOTS - 1);

	typedef enum logic [2:0] {S_CLR, S_IDLE, S_RMW, S_SCAN, S_DONE} state_t;

	state_t        st_q;
	logic [IW-1:0] clr_q, cur_q, slot_q, scan_q, who_q, addr_s1;
	logic [2:0]    cmd_q, tstate_q;
	logic          user_q, issuing_q, refresh_q, found_q, v_s1;
	logic [31:0]   now_q, sig_q;
	logic [8:0]    best_q;
	logic          sw_q, none_q, stall_q;
	logic          out_valid_q, out_sw_q, out_none_q, out_stall_q;
	logic [5:0]    out_task_q;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	row_t          wdata, rdata, scan_row;
	logic          accept, in_range, cand, nfound, tick_sched, row_last;
	logic [8:0]    nbest;
	logic [IW-1:0] nwho;

	ctpts_ram #(.WIDTH(ROW_W), .DEPTH(TASK_SLOTS)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign in_ch.ready = (st_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign in_range    = ({3'b000, in_ch.slot} < 9'(TASK_SLOTS));
	assign tick_sched  = (rdata.credit <= 9'd1) && user_q;
	assign row_last    = v_s1 && (addr_s1 == '0);

	// update one row during a scan: alarms and wakeups, or credit refresh; fold it into the pick
	always_comb begin
		scan_row = rdata;
		if (!refresh_q) begin
			if (addr_s1 != '0 && rdata.used) begin
				if (rdata.alarm != 32'd0 && rdata.alarm < now_q) begin
					scan_row.pend  = rdata.pend | SIG_ALRM_BIT;
					scan_row.alarm = 32'd0;
				end
				if ((scan_row.pend & ~(~SIG_UNBLOCKABLE & rdata.blk)) != 32'd0 &&
					rdata.st == ST_INTERRUPTIBLE) begin
					scan_row.st = ST_RUNNING;
				end
			end
		end else if (rdata.used) begin
			scan_row.credit = {1'b0, rdata.credit[8:1]} + {1'b0, rdata.prio};
		end
		cand   = scan_row.used && scan_row.st == ST_RUNNING &&
			(!found_q || scan_row.credit > best_q);
		nfound = found_q || cand;
		nbest  = cand ? scan_row.credit : best_q;
		nwho   = cand ? addr_s1 : who_q;
	end

	// select table read and write
	always_comb begin
		we    = 1'b0;
		waddr = slot_q;
		wdata = rdata;
		raddr = scan_q;
		unique case (st_q)
			S_CLR: begin
				we          = 1'b1;
				waddr       = clr_q;
				wdata       = '0;
				if (clr_q == '0) begin
					wdata.used   = 1'b1;
					wdata.credit = CREDIT_INIT;
					wdata.prio   = PRIO_INIT;
				end
			end
			S_IDLE: begin
				raddr = (in_ch.cmd == CMD_TICK) ? cur_q : IW'(in_ch.slot);
				if (accept && in_ch.cmd == CMD_LOAD && in_range) begin
					we          = 1'b1;
					waddr       = IW'(in_ch.slot);
					wdata.used   = in_ch.present;
					wdata.st     = in_ch.task_state;
					wdata.prio   = in_ch.priority_req;
					wdata.credit = in_ch.credit;
					wdata.alarm  = in_ch.alarm_at;
					wdata.blk    = in_ch.blocked_mask;
					wdata.pend   = in_ch.signal_bits;
				end
			end
			S_RMW: begin
				we = 1'b1;
				case (cmd_q)
					CMD_TICK: begin
						waddr        = cur_q;
						wdata.credit = (rdata.credit > 9'd1) ? rdata.credit - 9'd1 : 9'd0;
					end
					CMD_POST:  wdata.pend = rdata.pend | sig_q;
					default:   wdata.st   = tstate_q;
				endcase
			end
			S_SCAN: begin
				we    = v_s1;
				waddr = addr_s1;
				wdata = scan_row;
			end
			default: ;
		endcase
	end

	// sequencer: command decode, scans, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLR;
			clr_q       <= '0;
			cur_q       <= '0;
			issuing_q   <= 1'b0;
			refresh_q   <= 1'b0;
			found_q     <= 1'b0;
			v_s1        <= 1'b0;
			sw_q        <= 1'b0;
			none_q      <= 1'b0;
			stall_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready && st_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			v_s1    <= (st_q == S_SCAN) && issuing_q;
			addr_s1 <= scan_q;
			if (st_q == S_SCAN && issuing_q) begin
				if (scan_q == '0) begin
					issuing_q <= 1'b0;
				end else begin
					scan_q <= scan_q - 1'b1;
				end
			end
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= in_ch.cmd;
						user_q   <= in_ch.user_mode;
						now_q    <= in_ch.now_ticks;
						slot_q   <= IW'(in_ch.slot);
						sig_q    <= in_ch.signal_bits;
						tstate_q <= in_ch.task_state;
						sw_q     <= 1'b0;
						none_q   <= 1'b0;
						stall_q  <= 1'b0;
						if (in_ch.cmd == CMD_TICK ||
							((in_ch.cmd == CMD_POST || in_ch.cmd == CMD_STATE) && in_range)) begin
							st_q <= S_RMW;
						end else if (in_ch.cmd == CMD_SCHED) begin
							st_q      <= S_SCAN;
							sw_q      <= 1'b1;
							scan_q    <= LAST;
							issuing_q <= 1'b1;
							refresh_q <= 1'b0;
							found_q   <= 1'b0;
							best_q    <= '0;
						end else begin
							st_q <= S_DONE;
						end
					end
				end
				S_RMW: begin
					if (cmd_q == CMD_TICK && tick_sched) begin
						st_q      <= S_SCAN;
						sw_q      <= 1'b1;
						scan_q    <= LAST;
						issuing_q <= 1'b1;
						refresh_q <= 1'b0;
						found_q   <= 1'b0;
						best_q    <= '0;
					end else begin
						st_q <= S_DONE;
					end
				end
				S_SCAN: begin
					// accumulate the pick; the last row decides directly
					if (v_s1 && !row_last) begin
						found_q <= nfound;
						best_q  <= nbest;
						who_q   <= nwho;
					end
					if (row_last) begin
						if (!refresh_q) begin
							if (!nfound) begin
								cur_q  <= '0;
								none_q <= 1'b1;
								st_q   <= S_DONE;
							end else if (nbest != 9'd0) begin
								cur_q <= nwho;
								st_q  <= S_DONE;
							end else begin
								// refresh credits and pick again
								refresh_q <= 1'b1;
								scan_q    <= LAST;
								issuing_q <= 1'b1;
								found_q   <= 1'b0;
								best_q    <= '0;
							end
						end else begin
							if (nbest == 9'd0) begin
								stall_q <= 1'b1;
							end else begin
								cur_q <= nwho;
							end
							st_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_sw_q    <= sw_q;
						out_none_q  <= none_q;
						out_stall_q <= stall_q;
						out_task_q  <= 6'(cur_q);
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.switched          = out_sw_q;
	assign out_ch.next_task         = out_task_q;
	assign out_ch.none_runnable     = out_none_q;
	assign out_ch.zero_credit_stall = out_stall_q;

	// current task changes only at the end of a scan
	a_cur_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SCAN && !row_last) |=> $stable(cur_q))
		else $error("current task changed mid-scan");

	// a scan row is in flight only during a scan
	a_s1_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> st_q == S_SCAN)
		else $error("scan row outside scan");

	// a stall is only reported after a refresh
	a_stall_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stall_q) |-> $past(refresh_q))
		else $error("stall without credit refresh");

	// current task stays inside the table
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_q} < (IW + 1)'(TASK_SLOTS)))
		else $error("current task out of range");

endmodule

// File: bench/ctpts_tb_if.sv
// Testbench-side view of the scheduler channels.
// The channel interfaces themselves come with the RTL (rtl/ctpts_if.sv); nothing else here.
// Imports ctpts_pkg; defines the result record used by the checker and the command record.
package ctpts_tb_pkg;
	import ctpts_pkg::*;

	typedef struct packed {
		logic       switched;
		logic [5:0] next_task;
		logic       none_runnable;
		logic       zero_credit_stall;
	} sched_result_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        user_mode;
		logic [31:0] now_ticks;
		logic [5:0]  slot;
		logic        present;
		logic [2:0]  task_state;
		logic [7:0]  priority_req;
		logic [8:0]  credit;
		logic [31:0] alarm_at;
		logic [31:0] blocked_mask;
		logic [31:0] signal_bits;
	} sched_cmd_t;
endpackage

// File: bench/testbench.sv
// Testbench for counter_priority_task_scheduler: drives commands, predicts each
// result with a task-table model of its own and checks every result in order.
// Depends on ctpts_pkg, ctpts_tb_pkg, ctpts_in_if and ctpts_out_if.
module testbench;
	import ctpts_pkg::*;
	import ctpts_tb_pkg::*;

	localparam int SLOTS = 64;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int   errors;
	bit   calm;
	bit   hold_rx;
	int   idle_cycles;

	ctpts_in_if  in_ch();
	ctpts_out_if out_ch();

	counter_priority_task_scheduler dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	// Predicted task table
	logic        m_used  [SLOTS];
	logic [2:0]  m_st    [SLOTS];
	logic [8:0]  m_cred  [SLOTS];
	logic [7:0]  m_prio  [SLOTS];
	logic [31:0] m_alarm [SLOTS];
	logic [31:0] m_pend  [SLOTS];
	logic [31:0] m_blk   [SLOTS];
	logic [5:0]  m_cur;

	sched_result_t expected_results[$];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	task automatic table_reset();
		for (int i = 0; i < SLOTS; i++) begin
			m_used[i] = (i == 0);
			m_st[i] = ST_RUNNING;
			m_cred[i] = (i == 0) ? CREDIT_INIT : 9'd0;
			m_prio[i] = (i == 0) ? PRIO_INIT : 8'd0;
			m_alarm[i] = 0;
			m_pend[i] = 0;
			m_blk[i] = 0;
		end
		m_cur = 0;
	endtask

	// Find the running slot with the most credit, higher slot winning ties
	function automatic bit best_running(output int who, output int best);
		bit found;
		found = 0;
		who = 0;
		best = 0;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (m_used[i] && m_st[i] == ST_RUNNING && (!found || m_cred[i] > best)) begin
				found = 1;
				best = m_cred[i];
				who = i;
			end
		return found;
	endfunction

	function automatic void schedule_pass(input logic [31:0] now, output logic none,
			output logic stall);
		int who;
		int best;
		none = 0;
		stall = 0;
		// Fire alarms and wake signalled interruptible tasks
		for (int i = SLOTS - 1; i >= 1; i--) begin
			if (!m_used[i])
				continue;
			if (m_alarm[i] != 0 && m_alarm[i] < now) begin
				m_pend[i] |= SIG_ALRM_BIT;
				m_alarm[i] = 0;
			end
			if ((m_pend[i] & ~(~SIG_UNBLOCKABLE & m_blk[i])) != 0 &&
					m_st[i] == ST_INTERRUPTIBLE)
				m_st[i] = ST_RUNNING;
		end
		if (!best_running(who, best)) begin
			none = 1;
			m_cur = 0;
			return;
		end
		// Refresh credits once when the best is empty
		if (best == 0) begin
			for (int i = 0; i < SLOTS; i++)
				if (m_used[i])
					m_cred[i] = (m_cred[i] >> 1) + m_prio[i];
			void'(best_running(who, best));
			if (best == 0) begin
				stall = 1;
				return;
			end
		end
		m_cur = 6'(who);
	endfunction

	function automatic sched_result_t predict_command(input sched_cmd_t c);
		sched_result_t r;
		logic sched;
		logic none;
		logic stall;
		sched = 0;
		none = 0;
		stall = 0;
		case (c.cmd)
			CMD_TICK: begin
				if (m_cred[m_cur] > 1)
					m_cred[m_cur]--;
				else begin
					m_cred[m_cur] = 0;
					sched = c.user_mode;
				end
			end
			CMD_SCHED: sched = 1;
			CMD_LOAD: begin
				m_used[c.slot] = c.present;
				m_st[c.slot] = c.task_state;
				m_prio[c.slot] = c.priority_req;
				m_cred[c.slot] = c.credit;
				m_alarm[c.slot] = c.alarm_at;
				m_blk[c.slot] = c.blocked_mask;
				m_pend[c.slot] = c.signal_bits;
			end
			CMD_POST: m_pend[c.slot] |= c.signal_bits;
			CMD_STATE: m_st[c.slot] = c.task_state;
			default: ;
		endcase
		if (sched)
			schedule_pass(c.now_ticks, none, stall);
		r.switched = sched;
		r.next_task = m_cur;
		r.none_runnable = none;
		r.zero_credit_stall = stall;
		return r;
	endfunction

	// Drive one command and wait for its transfer; valid stays up until the next idle
	task automatic send_command(input sched_cmd_t c);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_ch.valid <= 1;
		{in_ch.cmd, in_ch.user_mode, in_ch.now_ticks, in_ch.slot, in_ch.present,
			in_ch.task_state, in_ch.priority_req, in_ch.credit, in_ch.alarm_at,
			in_ch.blocked_mask, in_ch.signal_bits} <= c;
		do
			@(posedge clk);
		while (!in_ch.ready);
		expected_results.push_back(predict_command(c));
		@(negedge clk);
	endtask

	function automatic sched_cmd_t random_command();
		sched_cmd_t c;
		logic [159:0] raw;
		int pick;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		c = raw[158:0];
		pick = $urandom_range(0, 99);
		if (pick < 30) c.cmd = CMD_TICK;
		else if (pick < 45) c.cmd = CMD_SCHED;
		else if (pick < 70) c.cmd = CMD_LOAD;
		else if (pick < 82) c.cmd = CMD_POST;
		else if (pick < 95) c.cmd = CMD_STATE;
		else c.cmd = 3'($urandom_range(5, 7));
		// Keep most slots low so loaded tasks take part in picks
		if ($urandom_range(0, 3) != 0)
			c.slot = 6'($urandom_range(0, 7));
		if ($urandom_range(0, 2) != 0)
			c.task_state = 3'($urandom_range(0, 1));
		if ($urandom_range(0, 2) != 0)
			c.credit = 9'($urandom_range(0, 20));
		if ($urandom_range(0, 2) != 0)
			c.priority_req = 8'($urandom_range(0, 20));
		if ($urandom_range(0, 1) != 0)
			c.present = 1'b1;
		if ($urandom_range(0, 2) != 0)
			c.alarm_at = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 2000);
		if ($urandom_range(0, 1) != 0)
			c.now_ticks = $urandom_range(0, 2000);
		if ($urandom_range(0, 1) != 0)
			c.signal_bits = 32'(1) << $urandom_range(0, 31);
		return c;
	endfunction

	function automatic sched_cmd_t make_command(input cmd_t op, input int s = 0,
			input logic [2:0] st = ST_RUNNING, input logic [7:0] pr = 0,
			input logic [8:0] cr = 0);
		sched_cmd_t c;
		c = '0;
		c.cmd = op;
		c.slot = 6'(s);
		c.present = 1'b1;
		c.task_state = st;
		c.priority_req = pr;
		c.credit = cr;
		c.user_mode = 1'b1;
		return c;
	endfunction

	task automatic test_extremes();
		sched_cmd_t c;
		c = '1;
		c.cmd = CMD_LOAD;
		c.task_state = ST_INTERRUPTIBLE;
		send_command(c);
		c = '1;
		c.cmd = CMD_SCHED;
		send_command(c);
		send_command(make_command(CMD_LOAD, 63, 3'd7, 8'hff, 9'h1ff));
		send_command(make_command(CMD_SCHED));
		c = '0;
		c.cmd = 3'd5;
		send_command(c);
		c.cmd = 3'd7;
		send_command(c);
	endtask

	task automatic test_ticks_and_refresh();
		send_command(make_command(CMD_LOAD, 1, ST_RUNNING, 8'd0, 9'd2));
		repeat (4) send_command(make_command(CMD_TICK));
		send_command(make_command(CMD_LOAD, 2, ST_RUNNING, 8'd3, 9'd0));
		send_command(make_command(CMD_SCHED));
	endtask

	task automatic test_signals_and_alarms();
		sched_cmd_t c;
		c = make_command(CMD_LOAD, 4, ST_INTERRUPTIBLE, 8'd5, 9'd7);
		c.alarm_at = 100;
		send_command(c);
		c = make_command(CMD_SCHED);
		c.now_ticks = 101;
		send_command(c);
		c = make_command(CMD_LOAD, 5, ST_INTERRUPTIBLE, 8'd5, 9'd9);
		c.blocked_mask = '1;
		c.signal_bits = SIG_UNBLOCKABLE;
		send_command(c);
		send_command(make_command(CMD_SCHED));
		c = make_command(CMD_POST, 6);
		c.signal_bits = 32'h8000_0001;
		send_command(c);
		send_command(make_command(CMD_STATE, 5, 3'd4));
	endtask

	task automatic test_stall_and_none();
		// Everything parked or zero priority
		for (int i = 0; i < 8; i++)
			send_command(make_command(CMD_LOAD, i, ST_RUNNING, 8'd0, 9'd0));
		send_command(make_command(CMD_SCHED));
		for (int i = 0; i < 8; i++)
			send_command(make_command(CMD_STATE, i, 3'd2));
		send_command(make_command(CMD_SCHED));
	endtask

	// Receiver clears hold_rx once its long hold is over
	task automatic test_backpressure();
		hold_rx = 1;
		repeat (40) send_command(random_command());
	endtask

	task automatic test_random(input int n);
		repeat (n) send_command(random_command());
	endtask

	// Receiver: random stalls, one long hold when hold_rx is set
	initial begin
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				out_ch.ready <= 0;
				repeat (300) @(negedge clk);
				hold_rx = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			out_ch.ready <= 1;
		end
	end

	// Check each result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sched_result_t e;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (out_ch.switched !== e.switched) begin
					$error("switched exp %0d got %0d", e.switched, out_ch.switched);
					errors++;
				end
				if (out_ch.next_task !== e.next_task) begin
					$error("next_task exp %0d got %0d", e.next_task, out_ch.next_task);
					errors++;
				end
				if (out_ch.none_runnable !== e.none_runnable) begin
					$error("none_runnable exp %0d got %0d", e.none_runnable,
						out_ch.none_runnable);
					errors++;
				end
				if (out_ch.zero_credit_stall !== e.zero_credit_stall) begin
					$error("zero_credit_stall exp %0d got %0d", e.zero_credit_stall,
						out_ch.zero_credit_stall);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL counter_priority_task_scheduler");
			$finish;
		end
	end

	initial begin
		clk = 0;
		errors = 0;
		calm = 0;
		hold_rx = 0;
		idle_cycles = 0;
		arst_n = 0;
		in_ch.valid = 0;
		{in_ch.cmd, in_ch.user_mode, in_ch.now_ticks, in_ch.slot, in_ch.present,
			in_ch.task_state, in_ch.priority_req, in_ch.credit, in_ch.alarm_at,
			in_ch.blocked_mask, in_ch.signal_bits} = '0;
		table_reset();
		repeat (10) @(negedge clk);
		arst_n = 1;
		test_extremes();
		test_ticks_and_refresh();
		test_signals_and_alarms();
		test_stall_and_none();
		test_backpressure();
		test_random(700);
		calm = 1;
		test_random(170);
		in_ch.valid <= 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("PASS counter_priority_task_scheduler");
		else
			$display("FAIL counter_priority_task_scheduler");
		$finish;
	end
endmodule
